// ===== design/hws_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// hws_pkg: shared types and constants for the harmonic weighted smoother
// Tap weight table, controller/datapath command and status structs, FSM codes.
// -----------------------------------------------------------------------------
package hws_pkg;

  // tap weights round(65536 / (dist + 1)), Q1.16, dist 0..32
  localparam int W_BITS   = 17;
  localparam int W_IDX    = 6;
  localparam int W_DEPTH  = 33;
  localparam logic [W_BITS-1:0] WEIGHT_TABLE [W_DEPTH] = '{
    17'd65536, 17'd32768, 17'd21845, 17'd16384, 17'd13107, 17'd10923, 17'd9362,
    17'd8192,  17'd7282,  17'd6554,  17'd5958,  17'd5461,  17'd5041,  17'd4681,
    17'd4369,  17'd4096,  17'd3855,  17'd3641,  17'd3449,  17'd3277,  17'd3121,
    17'd2979,  17'd2849,  17'd2731,  17'd2621,  17'd2521,  17'd2427,  17'd2341,
    17'd2260,  17'd2185,  17'd2114,  17'd2048,  17'd1986
  };

  localparam int CNT_BITS  = 5;   // series counters
  localparam int CMP_BITS  = 7;   // common width for count/half-width compares
  localparam int WSUM_BITS = 20;  // sum of weights, up to 2*32+1 taps
  localparam int ACC_EXTRA = 21;  // accumulator growth over the sample width
  localparam int HW_BITS   = 4;   // half-width register
  localparam logic [HW_BITS-1:0] HW_RESET = 4'd2;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DECIDE = 5'b00010,
    ST_MAC    = 5'b00100,
    ST_DIV    = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_e;

  typedef struct packed {
    logic load;       // take input sample, update counters
    logic mac_start;  // set up a new output
    logic mac_step;   // one tap
    logic div_start;  // load divider
    logic div_step;   // one quotient bit
    logic emit;       // write the output register
    logic clear;      // end of series
  } cmd_t;

  typedef struct packed {
    logic work;       // an output is due
    logic last_q;     // current sample is the last of its series
    logic mac_last;   // final tap in this cycle
    logic div_last;   // final quotient bit in this cycle
    logic out_free;   // output register can take a value
  } sts_t;

endpackage

// ===== design/hws_ctrl.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// hws_ctrl: sequencing FSM
// Steps each accepted sample through output decision, tap MAC, division, emit.
// -----------------------------------------------------------------------------
module hws_ctrl (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  hws_pkg::sts_t sts_i,
  output hws_pkg::cmd_t cmd_o
);
  import hws_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts_i.work) begin
          cmd_o.mac_start = 1'b1;
          state_d         = ST_MAC;
        end else begin
          cmd_o.clear = sts_i.last_q;
          state_d     = ST_IDLE;
        end
      end
      ST_MAC: begin
        cmd_o.mac_step = 1'b1;
        if (sts_i.mac_last) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        // first cycle here loads the divider, the rest produce bits
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_DECIDE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    cmd_o.div_start = (state_q == ST_MAC) && sts_i.mac_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/hws_dp.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// hws_dp: smoother datapath
// Sample window, series counters, serial MAC, restoring divider, output register.
// -----------------------------------------------------------------------------
module hws_dp #(
  parameter int MAX_HALF_WIDTH = 8,
  parameter int SAMPLE_BITS    = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hws_pkg::HW_BITS-1:0]   cfg_wdata_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          last_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] smoothed_o,
  output logic                          last_out_o,
  input  hws_pkg::cmd_t                 cmd_i,
  output hws_pkg::sts_t                 sts_o
);
  import hws_pkg::*;

  localparam int DEPTH = 2 * MAX_HALF_WIDTH + 1;
  localparam int IW    = $clog2(DEPTH);
  localparam int NWW   = $clog2(MAX_HALF_WIDTH + 1);
  localparam int OW    = $clog2(DEPTH + 32) + 1;
  localparam int AW    = SAMPLE_BITS + ACC_EXTRA;
  localparam int DCW   = $clog2(SAMPLE_BITS + 1);
  localparam logic [CMP_BITS-1:0] MAX_C = CMP_BITS'(MAX_HALF_WIDTH);

  logic [HW_BITS-1:0]            hw_q;
  logic signed [SAMPLE_BITS-1:0] win_q [DEPTH];
  logic [CNT_BITS-1:0]           seen_q, given_q, d_q;
  logic                          last_q, lastout_sel_q, neg_q;
  logic [IW-1:0]                 k_q;
  logic signed [AW-1:0]          acc_q;
  logic [WSUM_BITS-1:0]          wsum_q;
  logic [WSUM_BITS-1:0]          rem_q;
  logic [SAMPLE_BITS-1:0]        dvd_q;
  logic [DCW-1:0]                dcnt_q;
  logic                          out_valid_q, last_out_q;
  logic signed [SAMPLE_BITS-1:0] smoothed_q;

  // effective half-width, clamped
  logic [CMP_BITS-1:0] hw_c, nw_c, pend_c;
  logic [NWW-1:0]      nw;
  logic [CNT_BITS-1:0] pend;
  logic                pend_gt;

  assign hw_c    = CMP_BITS'(hw_q);
  assign nw_c    = (hw_c > MAX_C) ? MAX_C : hw_c;
  assign nw      = NWW'(nw_c);
  assign pend    = seen_q - given_q;
  assign pend_c  = CMP_BITS'(pend);
  assign pend_gt = pend_c > nw_c;

  // tap addressing
  logic signed [OW-1:0]   o_s;
  logic                   tap_ok;
  logic [IW-1:0]          tap_dist;
  logic [W_BITS-1:0]      wt;
  logic signed [SAMPLE_BITS+W_BITS:0] prod;
  logic signed [SAMPLE_BITS-1:0]      tap_smp;

  assign o_s    = $signed(OW'(d_q)) - $signed(OW'(nw)) + $signed(OW'(k_q));
  assign tap_ok = !o_s[OW-1] && (o_s < $signed(OW'(DEPTH)))
                  && (o_s < $signed(OW'(seen_q)));
  assign tap_dist = (k_q >= IW'(nw)) ? (k_q - IW'(nw)) : (IW'(nw) - k_q);
  assign wt     = WEIGHT_TABLE[W_IDX'(tap_dist)];
  assign tap_smp = win_q[o_s[IW-1:0]];
  assign prod   = $signed({1'b0, wt}) * tap_smp;

  // divider
  logic [AW-1:0]          mag;
  logic [WSUM_BITS:0]     trial;
  logic                   ge;
  assign mag   = (acc_q[AW-1] ? AW'(-acc_q) : AW'(acc_q)) + AW'(wsum_q >> 1);
  assign trial = {rem_q, dvd_q[SAMPLE_BITS-1]};
  assign ge    = trial >= {1'b0, wsum_q};

  assign sts_o.work     = pend_gt || (last_q && (pend != '0));
  assign sts_o.last_q   = last_q;
  assign sts_o.mac_last = k_q == IW'({nw, 1'b0});
  assign sts_o.div_last = !cmd_i.div_start && (dcnt_q == DCW'(SAMPLE_BITS - 1));
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q        <= HW_RESET;
      seen_q      <= '0;
      given_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        hw_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        if (seen_q != '1) begin
          seen_q <= seen_q + 1'b1;
        end else if (given_q != '0) begin
          given_q <= given_q - 1'b1;
        end
      end else if (cmd_i.clear) begin
        seen_q  <= '0;
        given_q <= '0;
      end else if (cmd_i.emit) begin
        given_q <= given_q + 1'b1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      win_q[0] <= sample_i;
      for (int i = 1; i < DEPTH; i++) begin
        win_q[i] <= win_q[i-1];
      end
      last_q <= last_i;
    end
    if (cmd_i.mac_start) begin
      d_q           <= pend - 1'b1;
      k_q           <= '0;
      acc_q         <= '0;
      wsum_q        <= '0;
      lastout_sel_q <= !pend_gt && (pend == CNT_BITS'(1));
    end else if (cmd_i.mac_step) begin
      if (tap_ok) begin
        acc_q  <= acc_q + AW'(prod);
        wsum_q <= wsum_q + WSUM_BITS'(wt);
      end
      k_q <= k_q + 1'b1;
    end
    if (cmd_i.emit) begin
      smoothed_q <= neg_q ? -$signed(dvd_q) : $signed(dvd_q);
      last_out_q <= lastout_sel_q;
    end
  end

  // divider loads in the cycle after the final tap so the sums are complete
  logic div_load_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_load_q <= 1'b0;
    end else begin
      div_load_q <= cmd_i.div_start;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dcnt_q <= '0;
    end else if (div_load_q) begin
      rem_q  <= WSUM_BITS'(mag >> SAMPLE_BITS);
      dvd_q  <= mag[SAMPLE_BITS-1:0];
      neg_q  <= acc_q[AW-1];
    end else if (cmd_i.div_step) begin
      rem_q  <= ge ? WSUM_BITS'(trial - {1'b0, wsum_q}) : WSUM_BITS'(trial);
      dvd_q  <= {dvd_q[SAMPLE_BITS-2:0], ge};
      dcnt_q <= dcnt_q + 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign smoothed_o  = smoothed_q;
  assign last_out_o  = last_out_q;

  // pending count never goes negative
  a_pend_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q >= given_q) else $error("given count above seen count");
  // at most MAX_HALF_WIDTH + 1 outputs outstanding
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_c <= MAX_C + CMP_BITS'(1)) else $error("pending outputs beyond window");
  // no overwrite of an untaken result
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i)) else $error("output overrun");

endmodule

// ===== design/harmonic_weighted_smoother_top.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// harmonic_weighted_smoother_top: edge-renormalised harmonic weighted smoother
// Centred window, tap weight 1/(|j|+1) in Q1.16, quotient rounded to nearest.
// -----------------------------------------------------------------------------
//  Channel  | Signals                          | Direction
//  ---------+----------------------------------+-----------
//  input    | in_valid_i/in_ready_o, sample_i, last_i       | in
//  output   | out_valid_o/out_ready_i, smoothed_o, last_out_o | out
//  config   | cfg_we_i, cfg_wdata_i (half-width)  | in
//
//  Each transfer in is followed by a decide step that starts a result or goes
//  back to idle. A result takes a serial tap MAC over its 2*nw+1 taps, a divider
//  load step, a restoring division with one quotient bit per cycle and an emit
//  step, then the next decide step.
//  Reset clears counters, the half-width (to 2) and the output valid.
//  A held output stalls only the emit step; the next input is taken once the
//  previous sample's results have all been written to the output register.
// -----------------------------------------------------------------------------
module harmonic_weighted_smoother_top #(
  parameter int MAX_HALF_WIDTH = 8,
  parameter int SAMPLE_BITS    = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hws_pkg::HW_BITS-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          last_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] smoothed_o,
  output logic                          last_out_o
);
  import hws_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencing: one sample at a time, one result at a time
  hws_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // window, counters, MAC, divider and output register
  hws_dp #(
    .MAX_HALF_WIDTH (MAX_HALF_WIDTH),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sample_i    (sample_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .smoothed_o  (smoothed_o),
    .last_out_o  (last_out_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

// ===== tb/sv/harmonic_weighted_smoother_checker.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// harmonic_weighted_smoother_checker: output predictor and scoreboard
// Snoops the config, input and output transfers, predicts each smoothed sample
// and compares it field by field against the oldest expected value.
// -----------------------------------------------------------------------------
module harmonic_weighted_smoother_checker #(
  parameter int MAX_HALF_WIDTH = 8,
  parameter int SAMPLE_BITS    = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hws_pkg::HW_BITS-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          last_i,
  input  logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  logic signed [SAMPLE_BITS-1:0] smoothed_o,
  input  logic                          last_out_o,
  output int                            fail_count_o,
  output int                            pending_count_o
);

  localparam int DEPTH = 2 * MAX_HALF_WIDTH + 1;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] smoothed;
    logic                          last_out;
  } smooth_res_t;

  logic signed [SAMPLE_BITS-1:0] hist_q [DEPTH];
  int unsigned                   seen_cnt;
  int unsigned                   given_cnt;
  logic [hws_pkg::HW_BITS-1:0]   nw_reg;
  smooth_res_t                   expected_q [$];
  int                            fails;

  assign fail_count_o    = fails;
  assign pending_count_o = expected_q.size();

  // weighted mean around the sample d places back from the newest
  function automatic logic signed [SAMPLE_BITS-1:0] weighted_mean(int d, int nw);
    longint acc;
    longint wsum;
    longint w;
    longint mag;
    longint quo;
    int     tap_dist;
    acc  = 0;
    wsum = 0;
    for (int o = d - nw; o <= d + nw; o++) begin
      if (o < 0 || o >= DEPTH || o >= int'(seen_cnt)) continue;
      tap_dist = (o > d) ? o - d : d - o;
      w    = (65536 + (tap_dist + 1) / 2) / (tap_dist + 1);
      acc  += w * longint'(hist_q[o]);
      wsum += w;
    end
    if (wsum == 0) return '0;
    mag = (acc < 0) ? -acc : acc;
    quo = (mag + wsum / 2) / wsum;
    return SAMPLE_BITS'((acc < 0) ? -quo : quo);
  endfunction

  task automatic predict_sample(logic signed [SAMPLE_BITS-1:0] s, logic lst);
    int          nw;
    int unsigned pend;
    smooth_res_t r;
    nw = (nw_reg > MAX_HALF_WIDTH) ? MAX_HALF_WIDTH : nw_reg;
    for (int k = DEPTH - 1; k > 0; k--) hist_q[k] = hist_q[k-1];
    hist_q[0] = s;
    if (seen_cnt < 31) seen_cnt++;
    else if (given_cnt > 0) given_cnt--;
    pend = seen_cnt - given_cnt;
    while (pend > nw) begin
      r.smoothed = weighted_mean(pend - 1, nw);
      r.last_out = 1'b0;
      expected_q.push_back(r);
      given_cnt++;
      pend--;
    end
    if (lst) begin
      while (pend > 0) begin
        r.smoothed = weighted_mean(pend - 1, nw);
        r.last_out = (pend == 1);
        expected_q.push_back(r);
        pend--;
      end
      seen_cnt  = 0;
      given_cnt = 0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    smooth_res_t e;
    if (!rst_ni) begin
      nw_reg    = hws_pkg::HW_RESET;
      seen_cnt  = 0;
      given_cnt = 0;
      fails     = 0;
      expected_q.delete();
      for (int k = 0; k < DEPTH; k++) hist_q[k] = '0;
    end else begin
      if (cfg_we_i) nw_reg = cfg_wdata_i;
      if (in_valid_i && in_ready_o) predict_sample(sample_i, last_i);
      if (out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("unexpected output transfer: smoothed %0d", smoothed_o);
          fails++;
        end else begin
          e = expected_q.pop_front();
          if (smoothed_o !== e.smoothed) begin
            $error("smoothed: expected %0d, got %0d", e.smoothed, smoothed_o);
            fails++;
          end
          if (last_out_o !== e.last_out) begin
            $error("last_out: expected %0d, got %0d", e.last_out, last_out_o);
            fails++;
          end
        end
      end
    end
  end

endmodule

// ===== tb/sv/harmonic_weighted_smoother_top_tb.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// harmonic_weighted_smoother_top_tb: testbench top for the smoother
// Drives directed and random series across several half-widths with random
// back-pressure; the checker predicts and compares every output transfer.
// -----------------------------------------------------------------------------
module harmonic_weighted_smoother_top_tb;

  localparam int SB       = 24;
  localparam int WD_LIMIT = 20000;   // cycles with no transfer before giving up
  localparam logic signed [SB-1:0] S_MAX = 24'sh7FFFFF;
  localparam logic signed [SB-1:0] S_MIN = 24'sh800000;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [hws_pkg::HW_BITS-1:0] cfg_wdata_i;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic signed [SB-1:0]        sample_i;
  logic                        last_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  logic signed [SB-1:0]        smoothed_o;
  logic                        last_out_o;
  int                          fail_cnt;
  int                          pend_cnt;
  int                          idle_cycles;
  bit                          calm;        // no idling in the final stretch
  bit                          stim_done;

  always begin
    clk_i = 1'b1; #10;
    clk_i = 1'b0; #10;
  end

  harmonic_weighted_smoother_top #(.MAX_HALF_WIDTH(8), .SAMPLE_BITS(SB)) u_top (.*);

  harmonic_weighted_smoother_checker #(.MAX_HALF_WIDTH(8), .SAMPLE_BITS(SB)) u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_ready_o,
    .sample_i, .last_i, .out_valid_o, .out_ready_i, .smoothed_o, .last_out_o,
    .fail_count_o(fail_cnt), .pending_count_o(pend_cnt)
  );

  // one input transfer; optional burst of idling first. Valid is left high
  // after the transfer and the next call replaces the payload in the same step.
  task automatic send_sample(logic signed [SB-1:0] s, logic lst);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    last_i     <= lst;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // change the half-width only once the block has drained
  task automatic set_half_width(logic [hws_pkg::HW_BITS-1:0] v);
    in_valid_i <= 1'b0;
    while (pend_cnt != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);   // residual work after the last output
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic random_series(int len);
    logic signed [SB-1:0] s;
    for (int k = 0; k < len; k++) begin
      case ($urandom_range(0, 3))
        0:       s = $urandom_range(0, 1) ? S_MAX : S_MIN;
        1:       s = SB'($signed($urandom_range(0, 200)) - 100);
        default: s = SB'($urandom);
      endcase
      send_sample(s, k == len - 1);
    end
  endtask

  // output-side back-pressure in random bursts
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b1;
    end else if (calm) begin
      out_ready_i <= 1'b1;
    end else if (out_ready_i && $urandom_range(0, 4) == 0) begin
      out_ready_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
      out_ready_i <= 1'b1;
    end
  end

  // watchdog: cycles with no transfer on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic [hws_pkg::HW_BITS-1:0] hw_list [6];
    int n_items;
    hw_list = '{4'd0, 4'd1, 4'd3, 4'd8, 4'd15, 4'd5};
    rst_ni = 1'b0; cfg_we_i = 1'b0; cfg_wdata_i = '0; in_valid_i = 1'b0;
    sample_i = '0; last_i = 1'b0; idle_cycles = 0; calm = 1'b0; stim_done = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: reset half-width, extremes, a lone sample, short series
    send_sample(S_MAX, 1'b0);
    send_sample(S_MIN, 1'b0);
    send_sample(S_MAX, 1'b0);
    send_sample(24'sd0, 1'b0);
    send_sample(-24'sd1, 1'b0);
    send_sample(24'sd1, 1'b1);
    send_sample(S_MIN, 1'b1);             // single-sample series
    send_sample(24'sd5, 1'b0);
    send_sample(-24'sd3, 1'b1);           // shorter than the window
    set_half_width(4'd0);                 // pass-through
    send_sample(S_MIN, 1'b0);
    send_sample(24'sh555555, 1'b0);
    send_sample(S_MAX, 1'b1);
    set_half_width(4'd15);                // above limit, clamps to eight
    random_series(3);
    random_series(20);

    // random series over a spread of half-widths, long ones past saturation
    n_items = 35;                         // directed items above
    for (int p = 0; n_items < 210; p++) begin
      set_half_width(p < 6 ? hw_list[p] : 4'($urandom_range(0, 15)));
      for (int r = 0; r < 3 && n_items < 210; r++) begin
        int len;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(32, 40) : $urandom_range(1, 14);
        if (len > 210 - n_items) len = 210 - n_items;
        if (n_items > 170) calm = 1'b1;
        random_series(len);
        n_items += len;
      end
    end

    in_valid_i <= 1'b0;
    while (pend_cnt != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
